>>> src/cmss_pkg.sv
// ----------------------------------------------------------------------------
// Control mode switch supervisor package
// Shared types, register indexes and field widths for the supervisor block.
// ----------------------------------------------------------------------------
package cmss_pkg;

    // Field widths.
    localparam int unsigned TimeW  = 32;
    localparam int unsigned UncW   = 16;
    localparam int unsigned ErrW   = 16;
    localparam int unsigned LimW   = 15;
    localparam int unsigned WinW   = 16;
    localparam int unsigned SqW    = 2 * ErrW;
    localparam int unsigned LimSqW = 2 * LimW;

    // Configuration port.
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_UNC_LIMIT  = 3'd0,
        REG_EVAL_WIN   = 3'd1,
        REG_MON_WIN    = 3'd2,
        REG_ANGLE_LIM  = 3'd3,
        REG_SPEED_LIM  = 3'd4
    } t_reg_idx;

    // Register reset values.
    localparam logic [UncW-1:0] UncLimitRst = 16'd128;
    localparam logic [WinW-1:0] EvalWinRst  = 16'd2000;
    localparam logic [WinW-1:0] MonWinRst   = 16'd5000;
    localparam logic [LimW-1:0] AngleLimRst = 15'd2145;
    localparam logic [LimW-1:0] SpeedLimRst = 15'd1280;

    // Control modes.
    typedef enum logic {
        MODE_CASCADE  = 1'b0,
        MODE_FEEDBACK = 1'b1
    } t_mode;

    // Switching phases.
    typedef enum logic [1:0] {
        PH_STABLE  = 2'd0,
        PH_EVAL    = 2'd1,
        PH_SWITCH  = 2'd2,
        PH_MONITOR = 2'd3
    } t_phase;

    // Per-item check results handed from the check stage to the state stage.
    typedef struct packed {
        logic [SqW-1:0] sq_north;
        logic [SqW-1:0] sq_east;
        logic [SqW-1:0] sq_down;
        logic           angle_ok;
        logic           unc_ok;
    } t_chk;

endpackage

>>> src/control_mode_switch_supervisor_unit.sv
// ----------------------------------------------------------------------------
// Control mode switch supervisor
// Chooses between cascade control and state feedback from estimator health,
// uncertainty and the current tracking errors.
// ----------------------------------------------------------------------------
// Every item is one supervisor tick and produces exactly one result. The
// block is a three-stage pipeline: an input register, a check stage holding
// the attitude and uncertainty flags and the squared velocity components, and
// a state stage that sums the squares, updates the mode, phase and start
// times, and loads the output register. It accepts one item per cycle while
// o_stall is low; each result is held in the output register while the
// output side stalls. The configuration registers sit on an APB port at
// byte addresses 0, 4, 8, 12 and 16 and are to be written only while no item
// is in flight.
module control_mode_switch_supervisor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cmss_pkg::TimeW-1:0]        i_now_ms,
    input  logic                              i_health_ok,
    input  logic [cmss_pkg::UncW-1:0]         i_uncertainty,
    input  logic signed [cmss_pkg::ErrW-1:0]  i_roll_error,
    input  logic signed [cmss_pkg::ErrW-1:0]  i_pitch_error,
    input  logic signed [cmss_pkg::ErrW-1:0]  i_vel_error_north,
    input  logic signed [cmss_pkg::ErrW-1:0]  i_vel_error_east,
    input  logic signed [cmss_pkg::ErrW-1:0]  i_vel_error_down,
    // Result item channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_active_mode,
    output logic [1:0]                        o_switch_phase,
    output logic                              o_switched,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cmss_pkg::AddrW-1:0]        paddr,
    input  logic [cmss_pkg::DataW-1:0]        pwdata,
    output logic [cmss_pkg::DataW-1:0]        prdata,
    output logic                              pready
);
    import cmss_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [UncW-1:0]   r_unc_limit;
    logic [WinW-1:0]   r_eval_win;
    logic [WinW-1:0]   r_mon_win;
    logic [LimW-1:0]   r_angle_lim;
    logic [LimW-1:0]   r_speed_lim;
    logic [LimSqW-1:0] r_speed_sq;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[AddrW-1:2]);

    // Register writes keep only the width of each register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unc_limit <= UncLimitRst;
            r_eval_win  <= EvalWinRst;
            r_mon_win   <= MonWinRst;
            r_angle_lim <= AngleLimRst;
            r_speed_lim <= SpeedLimRst;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_UNC_LIMIT: r_unc_limit <= pwdata[UncW-1:0];
                REG_EVAL_WIN:  r_eval_win  <= pwdata[WinW-1:0];
                REG_MON_WIN:   r_mon_win   <= pwdata[WinW-1:0];
                REG_ANGLE_LIM: r_angle_lim <= pwdata[LimW-1:0];
                REG_SPEED_LIM: r_speed_lim <= pwdata[LimW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Squared speed limit, refreshed every cycle from the register.
    always_ff @(posedge i_clk) begin
        r_speed_sq <= LimSqW'(r_speed_lim) * LimSqW'(r_speed_lim);
    end

    // Read back.
    always_comb begin
        unique case (cfg_idx)
            REG_UNC_LIMIT: prdata = DataW'(r_unc_limit);
            REG_EVAL_WIN:  prdata = DataW'(r_eval_win);
            REG_MON_WIN:   prdata = DataW'(r_mon_win);
            REG_ANGLE_LIM: prdata = DataW'(r_angle_lim);
            REG_SPEED_LIM: prdata = DataW'(r_speed_lim);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_ov;
    logic ov_free;
    logic s2_free;
    logic s1_free;
    logic adv1;
    logic adv2;
    logic acc_in;

    assign ov_free = !r_ov || !i_stall;
    assign adv2    = r_v2 && ov_free;
    assign s2_free = !r_v2 || ov_free;
    assign adv1    = r_v1 && s2_free;
    assign s1_free = !r_v1 || s2_free;
    assign o_stall = !s1_free;
    assign acc_in  = i_valid && s1_free;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_valid;
            end
            if (s2_free) begin
                r_v2 <= adv1;
            end
            if (ov_free) begin
                r_ov <= adv2;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------------
    logic [TimeW-1:0]        r1_now;
    logic                    r1_health;
    logic [UncW-1:0]         r1_unc;
    logic signed [ErrW-1:0]  r1_roll;
    logic signed [ErrW-1:0]  r1_pitch;
    logic signed [ErrW-1:0]  r1_north;
    logic signed [ErrW-1:0]  r1_east;
    logic signed [ErrW-1:0]  r1_down;

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r1_now    <= i_now_ms;
            r1_health <= i_health_ok;
            r1_unc    <= i_uncertainty;
            r1_roll   <= i_roll_error;
            r1_pitch  <= i_pitch_error;
            r1_north  <= i_vel_error_north;
            r1_east   <= i_vel_error_east;
            r1_down   <= i_vel_error_down;
        end
    end

    // ------------------------------------------------------------------------
    // Check stage
    // ------------------------------------------------------------------------
    t_chk             chk;
    t_chk             r2_chk;
    logic [TimeW-1:0] r2_now;
    logic             r2_health;

    cmss_check u_check (
        .i_roll_error      (r1_roll),
        .i_pitch_error     (r1_pitch),
        .i_vel_error_north (r1_north),
        .i_vel_error_east  (r1_east),
        .i_vel_error_down  (r1_down),
        .i_uncertainty     (r1_unc),
        .i_unc_limit       (r_unc_limit),
        .i_angle_limit     (r_angle_lim),
        .o_chk             (chk)
    );

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r2_chk    <= chk;
            r2_now    <= r1_now;
            r2_health <= r1_health;
        end
    end

    // ------------------------------------------------------------------------
    // State stage
    // ------------------------------------------------------------------------
    t_phase           r_phase;
    t_phase           n_phase;
    t_mode            r_mode;
    t_mode            n_mode;
    logic [TimeW-1:0] r_eval_start;
    logic [TimeW-1:0] n_eval_start;
    logic [TimeW-1:0] r_switch_start;
    logic [TimeW-1:0] n_switch_start;
    logic             n_switched;
    logic [SqW-1:0]   speed_sq;
    logic             speed_ok;
    logic             safe;
    logic             fit_ok;
    logic [TimeW-1:0] eval_elapsed;
    logic [TimeW-1:0] mon_elapsed;

    // The sum of three squares of 2^15 at most stays below 2^32.
    assign speed_sq     = r2_chk.sq_north + r2_chk.sq_east + r2_chk.sq_down;
    assign speed_ok     = speed_sq < SqW'(r_speed_sq);
    assign safe         = r2_chk.angle_ok && speed_ok && r2_health;
    assign fit_ok       = r2_health && r2_chk.unc_ok;
    assign eval_elapsed = r2_now - r_eval_start;
    assign mon_elapsed  = r2_now - r_switch_start;

    // Next phase, mode and start times for the item in this stage.
    always_comb begin
        n_phase        = r_phase;
        n_mode         = r_mode;
        n_eval_start   = r_eval_start;
        n_switch_start = r_switch_start;
        n_switched     = 1'b0;
        unique case (r_phase)
            PH_STABLE: begin
                if ((r_mode == MODE_CASCADE && fit_ok) ||
                    (r_mode == MODE_FEEDBACK && !fit_ok)) begin
                    n_phase      = PH_EVAL;
                    n_eval_start = r2_now;
                end
            end
            PH_EVAL: begin
                if (eval_elapsed > TimeW'(r_eval_win)) begin
                    if (safe) begin
                        n_phase        = PH_SWITCH;
                        n_switch_start = r2_now;
                    end else begin
                        n_phase = PH_STABLE;
                    end
                end
            end
            PH_SWITCH: begin
                n_mode     = t_mode'(~r_mode);
                n_switched = 1'b1;
                n_phase    = PH_MONITOR;
            end
            PH_MONITOR: begin
                if (mon_elapsed > TimeW'(r_mon_win)) begin
                    n_phase = PH_STABLE;
                end
            end
            default: begin
                n_phase = PH_STABLE;
            end
        endcase
    end

    // State register, advanced once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_STABLE;
            r_mode         <= MODE_CASCADE;
            r_eval_start   <= '0;
            r_switch_start <= '0;
        end else if (adv2) begin
            r_phase        <= n_phase;
            r_mode         <= n_mode;
            r_eval_start   <= n_eval_start;
            r_switch_start <= n_switch_start;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic       r_o_mode;
    logic [1:0] r_o_phase;
    logic       r_o_switched;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_o_mode     <= n_mode;
            r_o_phase    <= n_phase;
            r_o_switched <= n_switched;
        end
    end

    assign o_active_mode  = r_o_mode;
    assign o_switch_phase = r_o_phase;
    assign o_switched     = r_o_switched;

endmodule

>>> src/cmss_check.sv
// ----------------------------------------------------------------------------
// Supervisor check logic
// Takes the registered item fields and forms the attitude and uncertainty
// flags and the three squared velocity error components.
// ----------------------------------------------------------------------------
module cmss_check (
    input  logic signed [cmss_pkg::ErrW-1:0] i_roll_error,
    input  logic signed [cmss_pkg::ErrW-1:0] i_pitch_error,
    input  logic signed [cmss_pkg::ErrW-1:0] i_vel_error_north,
    input  logic signed [cmss_pkg::ErrW-1:0] i_vel_error_east,
    input  logic signed [cmss_pkg::ErrW-1:0] i_vel_error_down,
    input  logic        [cmss_pkg::UncW-1:0] i_uncertainty,
    input  logic        [cmss_pkg::UncW-1:0] i_unc_limit,
    input  logic        [cmss_pkg::LimW-1:0] i_angle_limit,
    output cmss_pkg::t_chk                   o_chk
);
    import cmss_pkg::*;

    // Magnitude of a signed error; the most negative value maps to 2^15.
    function automatic logic [ErrW-1:0] mag(input logic signed [ErrW-1:0] x);
        logic [ErrW-1:0] u;
        u = x;
        return x[ErrW-1] ? (~u + 1'b1) : u;
    endfunction

    logic [ErrW-1:0] roll_mag;
    logic [ErrW-1:0] pitch_mag;
    logic [ErrW-1:0] north_mag;
    logic [ErrW-1:0] east_mag;
    logic [ErrW-1:0] down_mag;

    assign roll_mag  = mag(i_roll_error);
    assign pitch_mag = mag(i_pitch_error);
    assign north_mag = mag(i_vel_error_north);
    assign east_mag  = mag(i_vel_error_east);
    assign down_mag  = mag(i_vel_error_down);

    // Attitude and uncertainty compares plus the three squares.
    always_comb begin
        o_chk.angle_ok = (roll_mag < {1'b0, i_angle_limit}) &&
                         (pitch_mag < {1'b0, i_angle_limit});
        o_chk.unc_ok   = i_uncertainty < i_unc_limit;
        o_chk.sq_north = SqW'(north_mag) * SqW'(north_mag);
        o_chk.sq_east  = SqW'(east_mag) * SqW'(east_mag);
        o_chk.sq_down  = SqW'(down_mag) * SqW'(down_mag);
    end

endmodule

>>> dv/tb_control_mode_switch_supervisor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Control mode switch supervisor testbench
// Feeds supervisor ticks through the valid/stall input channel and checks
// every result item against a cycle-free model of the mode and phase logic
// kept inside this bench. Directed ticks cover the window edges, the safety
// limits and time wraparound. Random ticks follow estimator regimes, so that
// evaluations, switches and monitoring windows happen under several register
// settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_control_mode_switch_supervisor_unit;
    import cmss_pkg::*;

    // Register values after reset, as the block's specification gives them.
    localparam logic [15:0] CfgUncReset   = 16'd128;
    localparam logic [15:0] CfgEvalReset  = 16'd2000;
    localparam logic [15:0] CfgMonReset   = 16'd5000;
    localparam logic [14:0] CfgAngleReset = 15'd2145;
    localparam logic [14:0] CfgSpeedReset = 15'd1280;

    // Index just past the last register; writes there must be ignored.
    localparam int unsigned RegCount       = 5;
    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned HoldSpacing    = 250;
    localparam int unsigned DrainCycles    = 20;
    localparam int unsigned MaxReports     = 10;
    localparam longint unsigned TimeoutNs  = 64'd5_000_000;

    // One supervisor tick as it goes onto the input ports.
    typedef struct packed {
        logic [TimeW-1:0]       now_ms;
        logic                   health_ok;
        logic [UncW-1:0]        uncertainty;
        logic signed [ErrW-1:0] roll;
        logic signed [ErrW-1:0] pitch;
        logic signed [ErrW-1:0] north;
        logic signed [ErrW-1:0] east;
        logic signed [ErrW-1:0] down;
    } t_tick;

    // Mode and phase reported after one tick.
    typedef struct {
        t_mode  mode;
        t_phase phase;
        logic   switched;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [TimeW-1:0]       i_now_ms = '0;
    logic                   i_health_ok = 1'b0;
    logic [UncW-1:0]        i_uncertainty = '0;
    logic signed [ErrW-1:0] i_roll_error = '0;
    logic signed [ErrW-1:0] i_pitch_error = '0;
    logic signed [ErrW-1:0] i_vel_error_north = '0;
    logic signed [ErrW-1:0] i_vel_error_east = '0;
    logic signed [ErrW-1:0] i_vel_error_down = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_active_mode;
    logic [1:0]             o_switch_phase;
    logic                   o_switched;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [AddrW-1:0]       paddr = '0;
    logic [DataW-1:0]       pwdata = '0;
    logic [DataW-1:0]       prdata;
    logic                   pready;

    control_mode_switch_supervisor_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_now_ms          (i_now_ms),
        .i_health_ok       (i_health_ok),
        .i_uncertainty     (i_uncertainty),
        .i_roll_error      (i_roll_error),
        .i_pitch_error     (i_pitch_error),
        .i_vel_error_north (i_vel_error_north),
        .i_vel_error_east  (i_vel_error_east),
        .i_vel_error_down  (i_vel_error_down),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_active_mode     (o_active_mode),
        .o_switch_phase    (o_switch_phase),
        .o_switched        (o_switched),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Ticks waiting to be sent and results the model predicts.
    t_tick    tick_q[$];
    t_verdict verdict_q[$];
    int unsigned fail_count = 0;

    // Model copy of the registers.
    logic [15:0] lim_unc   = CfgUncReset;
    logic [15:0] win_eval  = CfgEvalReset;
    logic [15:0] win_mon   = CfgMonReset;
    logic [14:0] lim_angle = CfgAngleReset;
    logic [14:0] lim_speed = CfgSpeedReset;

    // Model copy of the supervisor state.
    t_mode       mode_q = MODE_CASCADE;
    t_phase      phase_q = PH_STABLE;
    logic [31:0] eval_start_q = '0;
    logic [31:0] switch_start_q = '0;

    // Time line used when building random ticks.
    logic [31:0] clock_ms = '0;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MaxReports) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Magnitude of a signed error; the most negative value maps to 32768.
    function automatic logic [16:0] magnitude(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = v;
        return (w < 0) ? 17'(-w) : 17'(w);
    endfunction

    // Safety check that gates a switch at the end of the evaluation window.
    function automatic logic safe_to_switch(input t_tick t);
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] bound;
        logic        attitude_ok;
        n = magnitude(t.north);
        e = magnitude(t.east);
        d = magnitude(t.down);
        bound = 64'(lim_speed) * 64'(lim_speed);
        attitude_ok = (magnitude(t.roll) < lim_angle) && (magnitude(t.pitch) < lim_angle);
        return attitude_ok && (n * n + e * e + d * d < bound) && t.health_ok;
    endfunction

    // Advances the model by one tick and returns the result it reports.
    function automatic t_verdict supervise_tick(input t_tick t);
        t_verdict    v;
        logic        unc_ok;
        logic [31:0] elapsed;
        unc_ok = t.uncertainty < lim_unc;
        v.switched = 1'b0;
        case (phase_q)
            PH_STABLE: begin
                if ((mode_q == MODE_CASCADE && t.health_ok && unc_ok) ||
                    (mode_q == MODE_FEEDBACK && (!t.health_ok || !unc_ok))) begin
                    phase_q = PH_EVAL;
                    eval_start_q = t.now_ms;
                end
            end
            PH_EVAL: begin
                elapsed = t.now_ms - eval_start_q;
                if (elapsed > 32'(win_eval)) begin
                    if (safe_to_switch(t)) begin
                        phase_q = PH_SWITCH;
                        switch_start_q = t.now_ms;
                    end else begin
                        phase_q = PH_STABLE;
                    end
                end
            end
            PH_SWITCH: begin
                mode_q = (mode_q == MODE_CASCADE) ? MODE_FEEDBACK : MODE_CASCADE;
                v.switched = 1'b1;
                phase_q = PH_MONITOR;
            end
            default: begin
                elapsed = t.now_ms - switch_start_q;
                if (elapsed > 32'(win_mon)) begin
                    phase_q = PH_STABLE;
                end
            end
        endcase
        v.mode = mode_q;
        v.phase = phase_q;
        return v;
    endfunction

    function automatic t_tick tick_of(input logic [31:0] now, input logic healthy,
                                      input logic [15:0] unc,
                                      input logic signed [15:0] roll,
                                      input logic signed [15:0] pitch,
                                      input logic signed [15:0] north,
                                      input logic signed [15:0] east,
                                      input logic signed [15:0] down);
        t_tick t;
        t.now_ms = now;
        t.health_ok = healthy;
        t.uncertainty = unc;
        t.roll = roll;
        t.pitch = pitch;
        t.north = north;
        t.east = east;
        t.down = down;
        return t;
    endfunction

    // Random value of magnitude at most m with a random sign.
    function automatic logic signed [15:0] signed_within(input int unsigned m);
        logic signed [15:0] v;
        v = 16'($urandom_range(0, m));
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    // Time advance per tick, scaled to the current windows.
    function automatic logic [31:0] time_step();
        int unsigned wmax;
        int unsigned r;
        wmax = (win_eval > win_mon) ? win_eval : win_mon;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return $urandom;
        end else if (r < 3) begin
            return 32'd0;
        end
        return $urandom_range(0, wmax / 3 + 2);
    endfunction

    // Random ticks grouped in estimator regimes, so that well-formed
    // evaluate, switch and monitor sequences occur; some ticks are noise.
    task automatic queue_random_ticks(input int unsigned count);
        int unsigned regime_left;
        logic        healthy;
        logic        calm;
        logic        safe;
        t_tick       t;
        regime_left = 0;
        healthy = 1'b0;
        calm = 1'b0;
        safe = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            if (regime_left == 0) begin
                healthy = $urandom_range(0, 1);
                calm = $urandom_range(0, 1);
                safe = $urandom_range(0, 9) < 7;
                regime_left = $urandom_range(4, 24);
            end
            regime_left--;
            if ($urandom_range(0, 9) == 0) begin
                t = tick_of($urandom, $urandom_range(0, 1), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                clock_ms = clock_ms + time_step();
                t.now_ms = clock_ms;
                t.health_ok = ($urandom_range(0, 19) == 0) ? !healthy : healthy;
                if (calm && lim_unc != 0) begin
                    t.uncertainty = 16'($urandom_range(0, lim_unc - 1));
                end else begin
                    t.uncertainty = 16'($urandom_range(lim_unc, 16'hFFFF));
                end
                if (safe && lim_angle != 0) begin
                    t.roll = signed_within(lim_angle - 1);
                    t.pitch = signed_within(lim_angle - 1);
                end else begin
                    t.roll = 16'($urandom);
                    t.pitch = 16'($urandom);
                end
                // Half the limit per axis keeps the squared length below the squared limit.
                if (safe) begin
                    t.north = signed_within(lim_speed / 2);
                    t.east = signed_within(lim_speed / 2);
                    t.down = signed_within(lim_speed / 2);
                end else begin
                    t.north = 16'($urandom);
                    t.east = 16'($urandom);
                    t.down = 16'($urandom);
                end
            end
            tick_q.push_back(t);
        end
    endtask

    // APB write: setup cycle, then access cycle; the model follows on the write edge.
    task automatic write_reg(input int unsigned idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrW'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_UNC_LIMIT: lim_unc = value[15:0];
            REG_EVAL_WIN:  win_eval = value[15:0];
            REG_MON_WIN:   win_mon = value[15:0];
            REG_ANGLE_LIM: lim_angle = value[14:0];
            REG_SPEED_LIM: lim_speed = value[14:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every queued tick is sent and every result has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || i_valid || verdict_q.size() != 0);
    endtask

    // Sender: bursts of random length separated by random gaps.
    t_tick       on_wire;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                verdict_q.push_back(supervise_tick(on_wire));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    on_wire = tick_q.pop_front();
                    i_now_ms <= on_wire.now_ms;
                    i_health_ok <= on_wire.health_ok;
                    i_uncertainty <= on_wire.uncertainty;
                    i_roll_error <= on_wire.roll;
                    i_pitch_error <= on_wire.pitch;
                    i_vel_error_north <= on_wire.north;
                    i_vel_error_east <= on_wire.east;
                    i_vel_error_down <= on_wire.down;
                    i_valid <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result item and stalls on its own pattern, with a
    // long hold-off after 100 results and then every 250 results.
    int unsigned results_seen = 0;
    int unsigned next_hold_at = 100;
    int unsigned hold_left = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_pct = 0;
    t_verdict    want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    note_failure($sformatf("unexpected result mode %0d phase %0d switched %0d",
                                           o_active_mode, o_switch_phase, o_switched));
                end else begin
                    want = verdict_q.pop_front();
                    if (o_active_mode !== want.mode || o_switch_phase !== want.phase ||
                        o_switched !== want.switched) begin
                        note_failure($sformatf(
                            "result %0d: expected mode %0d phase %0d switched %0d, got %0d %0d %0d",
                            results_seen, want.mode, want.phase, want.switched,
                            o_active_mode, o_switch_phase, o_switched));
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (results_seen >= next_hold_at) begin
                hold_left = LongHoldCycles;
                next_hold_at += HoldSpacing;
                i_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                    pattern_left = $urandom_range(8, 64);
                end else begin
                    pattern_left--;
                end
                i_stall <= $urandom_range(0, 99) < stall_pct;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks with the reset register values. Field extremes while
        // uncertainty sits exactly at its limit, then the window edges (elapsed
        // equal to the window holds), a passing switch at the angle limit minus
        // one, failures on each safety term, the most negative velocity, the
        // squared-length edge, and a start time just before the 32-bit wrap.
        tick_q.push_back(tick_of(32'd100, 1'b1, 16'd128, 16'sd32767, -16'sd32768,
                                 16'sd32767, -16'sd32768, 16'sd32767));
        tick_q.push_back(tick_of(32'd110, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd120, 1'b1, 16'd127, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd2120, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd2121, 1'b1, 16'd0, 16'sd2144, -16'sd2144, 0, 0, 0));
        tick_q.push_back(tick_of(32'd2122, 1'b0, 16'hFFFF, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd7121, 1'b0, 16'hFFFF, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd7122, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd7130, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd7140, 1'b1, 16'hFFFF, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd9141, 1'b1, 16'd0, 16'sd2145, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd9150, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd11151, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd11160, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd13161, 1'b1, 16'd0, -16'sd32768, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd13170, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd15171, 1'b1, 16'd0, 0, 0, -16'sd32768, 0, 0));
        tick_q.push_back(tick_of(32'd15180, 1'b0, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd17181, 1'b1, 16'd0, 0, 0, 16'sd1279, 0, 0));
        tick_q.push_back(tick_of(32'd17182, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'd5, 1'b1, 16'd200, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'hFFFF_FFF0, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'h0000_07C0, 1'b1, 16'd0, 0, 0, 0, 0, 0));
        tick_q.push_back(tick_of(32'h0000_07C1, 1'b1, 16'd0, 0, 0, 16'sd1280, 0, 0));
        wait_idle();

        // Short windows and moderate limits; most switching activity.
        write_reg(REG_UNC_LIMIT, 32'd16384);
        write_reg(REG_EVAL_WIN, 32'd20);
        write_reg(REG_MON_WIN, 32'd40);
        write_reg(REG_ANGLE_LIM, 32'd2145);
        write_reg(REG_SPEED_LIM, 32'd1280);
        clock_ms = $urandom;
        queue_random_ticks(150);
        wait_idle();

        // Every register at its maximum; the upper data bits must be dropped.
        write_reg(REG_UNC_LIMIT, 32'hFFFF_FFFF);
        write_reg(REG_EVAL_WIN, 32'hFFFF_FFFF);
        write_reg(REG_MON_WIN, 32'hFFFF_FFFF);
        write_reg(REG_ANGLE_LIM, 32'hFFFF_FFFF);
        write_reg(REG_SPEED_LIM, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_0000;
        queue_random_ticks(60);
        wait_idle();

        // Every register at zero: no safety check can pass. A write past the
        // last register must leave everything unchanged.
        write_reg(REG_UNC_LIMIT, 32'd0);
        write_reg(REG_EVAL_WIN, 32'd0);
        write_reg(REG_MON_WIN, 32'd0);
        write_reg(REG_ANGLE_LIM, 32'd0);
        write_reg(REG_SPEED_LIM, 32'd0);
        write_reg(RegCount, $urandom);
        queue_random_ticks(50);
        wait_idle();

        // Smallest nonzero angle and speed limits with very short windows.
        write_reg(REG_UNC_LIMIT, $urandom);
        write_reg(REG_EVAL_WIN, $urandom_range(1, 10));
        write_reg(REG_MON_WIN, $urandom_range(1, 10));
        write_reg(REG_ANGLE_LIM, 32'd1);
        write_reg(REG_SPEED_LIM, 32'd1);
        queue_random_ticks(60);
        wait_idle();

        // Random settings.
        for (int unsigned k = 0; k < 3; k++) begin
            write_reg(REG_UNC_LIMIT, $urandom);
            write_reg(REG_EVAL_WIN, $urandom_range(0, 200));
            write_reg(REG_MON_WIN, $urandom_range(0, 200));
            write_reg(REG_ANGLE_LIM, $urandom);
            write_reg(REG_SPEED_LIM, $urandom);
            queue_random_ticks(60);
            wait_idle();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake or missing results.
    initial begin
        #(TimeoutNs);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
